FILE: design/tsf_pkg.sv
// tsf_pkg: constants, register and action codes, and the command bundle
// shared by the touch sample filter controller, datapath and top level.
// no dependencies.
package tsf_pkg;

  // sample grouping
  localparam int SPR         = 5;
  localparam int TRIM        = 1;
  localparam int TRIM_EFF    = (2 * TRIM >= SPR) ? (SPR - 1) / 2 : TRIM;
  localparam int KEEP        = SPR - 2 * TRIM_EFF;
  localparam int STORE_DEPTH = 4 * SPR;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CNT_W       = $clog2(SPR + 1);
  localparam int SORT_IDX_W  = $clog2(SPR);
  localparam int FILL_W      = $clog2(SPR + 1);

  // data widths
  localparam int SAMPLE_W = 12;
  localparam int COORD_W  = 16;
  localparam int GAIN_W   = 16;
  localparam int Q_FRAC   = 14;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // trimmed sum and divide-by-KEEP through a reciprocal multiply
  localparam int SUM_W     = $clog2(KEEP * (1 << SAMPLE_W));
  localparam int DIV_SH    = SUM_W + $clog2(KEEP);
  localparam int DIV_MUL_W = DIV_SH + 1;
  localparam int DIV_PROD_W = SUM_W + DIV_MUL_W;
  localparam logic [DIV_MUL_W-1:0] DIV_MUL = DIV_MUL_W'((1 << DIV_SH) / KEEP + 1);

  localparam int MAP_PROD_W = GAIN_W + SAMPLE_W + 1;

  localparam logic [SAMPLE_W-1:0] JITTER_RESET = SAMPLE_W'(50);
  localparam logic [COORD_W-1:0]  IDLE_COORD   = 16'hFFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RAW_MODE     = 3'd0,
    REG_X_GAIN       = 3'd1,
    REG_Y_GAIN       = 3'd2,
    REG_X_OFFSET     = 3'd3,
    REG_Y_OFFSET     = 3'd4,
    REG_JITTER_LIMIT = 3'd5
  } cfg_reg_t;

  typedef enum logic {
    ACT_SAMPLE = 1'b0,
    ACT_TICK   = 1'b1
  } action_t;

  // controller to datapath commands
  typedef struct packed {
    logic                  in_take;
    logic                  sort_clear;
    logic                  rd_en;
    logic [ADDR_W-1:0]     rd_addr;
    logic                  acc_en;
    logic                  acc_first;
    logic [SORT_IDX_W-1:0] acc_idx;
    logic                  div_en;
    logic                  mean_en;
    logic [1:0]            grp;
    logic                  mapx_en;
    logic                  mapy_en;
    logic                  mapd_en;
    logic                  update;
  } tsf_cmd_t;

endpackage

FILE: design/tsf_sort.sv
// tsf_sort: insertion sorter for one group of samples, one value per cycle
// with an indexed read of the sorted entries. uses tsf_pkg.
module tsf_sort (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                clear,
  input  logic                                ins_en,
  input  logic [tsf_pkg::SAMPLE_W-1:0]        ins_data,
  input  logic [tsf_pkg::SORT_IDX_W-1:0]      rd_idx,
  output logic [tsf_pkg::SAMPLE_W-1:0]        rd_data
);

  logic [tsf_pkg::SAMPLE_W-1:0] sorted [tsf_pkg::SPR];
  logic [tsf_pkg::SAMPLE_W-1:0] sorted_next [tsf_pkg::SPR];
  logic [tsf_pkg::FILL_W-1:0]   fill;
  logic [tsf_pkg::SPR-1:0]      gt;

  // empty slots count as larger than anything
  always_comb begin
    for (int k = 0; k < tsf_pkg::SPR; k++) begin
      gt[k] = (tsf_pkg::FILL_W'(k) >= fill) || (sorted[k] > ins_data);
    end
    sorted_next[0] = gt[0] ? ins_data : sorted[0];
    for (int k = 1; k < tsf_pkg::SPR; k++) begin
      if (!gt[k]) begin
        sorted_next[k] = sorted[k];
      end else if (gt[k-1]) begin
        sorted_next[k] = sorted[k-1];
      end else begin
        sorted_next[k] = ins_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (clear) begin
      fill <= '0;
    end else if (ins_en) begin
      fill <= fill + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ins_en && !clear) begin
      sorted <= sorted_next;
    end
  end

  assign rd_data = sorted[rd_idx];

endmodule

FILE: design/tsf_dp.sv
// tsf_dp: datapath of the touch sample filter: sample memory, sorter,
// trimmed mean, jitter check, calibration mapping, press tracking.
// uses tsf_pkg and tsf_sort.
module tsf_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  tsf_pkg::tsf_cmd_t                 cmd,
  input  logic                              action,
  input  logic [tsf_pkg::SAMPLE_W-1:0]      sample,
  input  logic                              pen_down,
  input  logic                              cfg_fire,
  input  logic [tsf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tsf_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic [tsf_pkg::COORD_W-1:0]       coord_x,
  output logic [tsf_pkg::COORD_W-1:0]       coord_y,
  output logic [tsf_pkg::COORD_W-1:0]       first_x,
  output logic [tsf_pkg::COORD_W-1:0]       first_y,
  output logic                              pressed,
  output logic                              new_press,
  output logic                              reading_ok
);

  // configuration
  logic                                raw_mode;
  logic signed [tsf_pkg::GAIN_W-1:0]   x_gain;
  logic signed [tsf_pkg::GAIN_W-1:0]   y_gain;
  logic signed [tsf_pkg::COORD_W-1:0]  x_offset;
  logic signed [tsf_pkg::COORD_W-1:0]  y_offset;
  logic [tsf_pkg::SAMPLE_W-1:0]        jitter_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_mode     <= 1'b0;
      x_gain       <= '0;
      y_gain       <= '0;
      x_offset     <= '0;
      y_offset     <= '0;
      jitter_limit <= tsf_pkg::JITTER_RESET;
    end else if (cfg_fire) begin
      unique case (cfg_index)
        tsf_pkg::REG_RAW_MODE:     raw_mode     <= cfg_data[0];
        tsf_pkg::REG_X_GAIN:       x_gain       <= cfg_data;
        tsf_pkg::REG_Y_GAIN:       y_gain       <= cfg_data;
        tsf_pkg::REG_X_OFFSET:     x_offset     <= cfg_data;
        tsf_pkg::REG_Y_OFFSET:     y_offset     <= cfg_data;
        tsf_pkg::REG_JITTER_LIMIT: jitter_limit <= cfg_data[tsf_pkg::SAMPLE_W-1:0];
        default: ;
      endcase
    end
  end

  // sample memory and write pointer
  logic [tsf_pkg::SAMPLE_W-1:0] store [tsf_pkg::STORE_DEPTH];
  logic [tsf_pkg::ADDR_W-1:0]   store_index;
  logic [tsf_pkg::SAMPLE_W-1:0] rd_data;
  logic                         rd_vld;
  logic                         take_sample;
  logic                         take_tick;

  assign take_sample = cmd.in_take && (action == tsf_pkg::ACT_SAMPLE);
  assign take_tick   = cmd.in_take && (action == tsf_pkg::ACT_TICK);

  always_ff @(posedge clk) begin
    if (take_sample) begin
      store[store_index] <= sample;
    end
    if (cmd.rd_en) begin
      rd_data <= store[cmd.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      store_index <= '0;
      rd_vld      <= 1'b0;
    end else begin
      rd_vld <= cmd.rd_en;
      if (take_tick) begin
        store_index <= '0;
      end else if (take_sample) begin
        store_index <= (store_index == tsf_pkg::ADDR_W'(tsf_pkg::STORE_DEPTH - 1)) ?
                       '0 : store_index + 1'b1;
      end
    end
  end

  // sort, trimmed sum, divide
  logic [tsf_pkg::SAMPLE_W-1:0]   sort_val;
  logic [tsf_pkg::SUM_W-1:0]      sum;
  logic [tsf_pkg::DIV_PROD_W-1:0] div_prod;
  logic [tsf_pkg::SAMPLE_W-1:0]   means [4];

  tsf_sort u_sort (
    .clk      (clk),
    .rst      (rst),
    .clear    (cmd.sort_clear),
    .ins_en   (rd_vld),
    .ins_data (rd_data),
    .rd_idx   (cmd.acc_idx),
    .rd_data  (sort_val)
  );

  always_ff @(posedge clk) begin
    if (cmd.acc_en) begin
      sum <= cmd.acc_first ? tsf_pkg::SUM_W'(sort_val) : sum + tsf_pkg::SUM_W'(sort_val);
    end
    if (cmd.div_en) begin
      div_prod <= tsf_pkg::DIV_PROD_W'(sum) * tsf_pkg::DIV_PROD_W'(tsf_pkg::DIV_MUL);
    end
    if (cmd.mean_en) begin
      means[cmd.grp] <= div_prod[tsf_pkg::DIV_SH +: tsf_pkg::SAMPLE_W];
    end
  end

  // jitter check and averaging
  logic [tsf_pkg::SAMPLE_W-1:0] dx, dy, ax, ay;
  logic                         check_ok;
  logic [tsf_pkg::SAMPLE_W:0]   sx, sy;

  always_comb begin
    dx = (means[0] > means[2]) ? means[0] - means[2] : means[2] - means[0];
    dy = (means[1] > means[3]) ? means[1] - means[3] : means[3] - means[1];
    check_ok = (dx < jitter_limit) && (dy < jitter_limit);
    sx = {1'b0, means[0]} + {1'b0, means[2]};
    sy = {1'b0, means[1]} + {1'b0, means[3]};
    ax = sx[tsf_pkg::SAMPLE_W:1];
    ay = sy[tsf_pkg::SAMPLE_W:1];
  end

  // calibration: one multiply shared by both axes
  function automatic logic [tsf_pkg::COORD_W-1:0] map_round(
    input logic signed [tsf_pkg::MAP_PROD_W-1:0] p,
    input logic signed [tsf_pkg::COORD_W-1:0]    off
  );
    logic signed [31:0] t;
    logic signed [31:0] adj;
    t   = 32'(p) + (32'(off) <<< tsf_pkg::Q_FRAC);
    adj = t + (t[31] ? 32'sd16383 : 32'sd0);
    return adj[tsf_pkg::Q_FRAC +: tsf_pkg::COORD_W];
  endfunction

  logic signed [tsf_pkg::MAP_PROD_W-1:0] map_prod;
  logic [tsf_pkg::COORD_W-1:0]           map_x, map_y;
  logic signed [tsf_pkg::GAIN_W-1:0]     mul_gain;
  logic [tsf_pkg::SAMPLE_W-1:0]          mul_val;

  assign mul_gain = cmd.mapy_en ? y_gain : x_gain;
  assign mul_val  = cmd.mapy_en ? ay : ax;

  always_ff @(posedge clk) begin
    if (cmd.mapx_en || cmd.mapy_en) begin
      map_prod <= mul_gain * $signed({1'b0, mul_val});
    end
    if (cmd.mapy_en) begin
      map_x <= map_round(map_prod, x_offset);
    end
    if (cmd.mapd_en) begin
      map_y <= map_round(map_prod, y_offset);
    end
  end

  // press tracking
  logic                        pen;
  logic                        down_flag;
  logic [tsf_pkg::COORD_W-1:0] cur_x, cur_y, press_x, press_y;
  logic [tsf_pkg::COORD_W-1:0] cur_x_next, cur_y_next, press_x_next, press_y_next;
  logic                        down_next, fresh, ok;

  always_ff @(posedge clk) begin
    if (take_tick) begin
      pen <= pen_down;
    end
  end

  always_comb begin
    cur_x_next   = cur_x;
    cur_y_next   = cur_y;
    press_x_next = press_x;
    press_y_next = press_y;
    down_next    = down_flag;
    fresh        = 1'b0;
    ok           = 1'b0;
    if (pen) begin
      ok = check_ok;
      if (check_ok) begin
        cur_x_next = raw_mode ? tsf_pkg::COORD_W'(ax) : map_x;
        cur_y_next = raw_mode ? tsf_pkg::COORD_W'(ay) : map_y;
      end
      if (!down_flag) begin
        down_next    = 1'b1;
        fresh        = 1'b1;
        press_x_next = cur_x_next;
        press_y_next = cur_y_next;
      end
    end else if (down_flag) begin
      down_next = 1'b0;
    end else begin
      press_x_next = '0;
      press_y_next = '0;
      cur_x_next   = tsf_pkg::IDLE_COORD;
      cur_y_next   = tsf_pkg::IDLE_COORD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      down_flag <= 1'b0;
      cur_x     <= '0;
      cur_y     <= '0;
      press_x   <= '0;
      press_y   <= '0;
    end else if (cmd.update) begin
      down_flag <= down_next;
      cur_x     <= cur_x_next;
      cur_y     <= cur_y_next;
      press_x   <= press_x_next;
      press_y   <= press_y_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      coord_x    <= cur_x_next;
      coord_y    <= cur_y_next;
      first_x    <= press_x_next;
      first_y    <= press_y_next;
      pressed    <= down_next;
      new_press  <= fresh;
      reading_ok <= ok;
    end
  end

endmodule

FILE: design/tsf_ctrl.sv
// tsf_ctrl: sequencer of the touch sample filter; steps the datapath through
// memory reads, sum, divide and mapping, and owns the output valid flag.
// uses tsf_pkg.
module tsf_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              action,
  input  logic              pen_down,
  output logic              out_valid,
  input  logic              out_ready,
  output tsf_pkg::tsf_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_SUM,
    S_DIV,
    S_MEAN,
    S_MAPX,
    S_MAPY,
    S_MAPD,
    S_FINISH
  } state_t;

  state_t                      state;
  logic [tsf_pkg::CNT_W-1:0]   cnt;
  logic [1:0]                  grp;
  logic [tsf_pkg::ADDR_W-1:0]  addr;
  logic                        slot_free;

  assign in_ready  = (state == S_IDLE);
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    cmd            = '0;
    cmd.in_take    = in_valid && in_ready;
    cmd.sort_clear = (state == S_IDLE) || (state == S_MEAN);
    cmd.rd_en      = (state == S_READ) && (cnt < tsf_pkg::CNT_W'(tsf_pkg::SPR));
    cmd.rd_addr    = addr;
    cmd.acc_en     = (state == S_SUM);
    cmd.acc_first  = (cnt == '0);
    cmd.acc_idx    = tsf_pkg::SORT_IDX_W'(tsf_pkg::TRIM_EFF) + cnt[tsf_pkg::SORT_IDX_W-1:0];
    cmd.div_en     = (state == S_DIV);
    cmd.mean_en    = (state == S_MEAN);
    cmd.grp        = grp;
    cmd.mapx_en    = (state == S_MAPX);
    cmd.mapy_en    = (state == S_MAPY);
    cmd.mapd_en    = (state == S_MAPD);
    cmd.update     = (state == S_FINISH) && slot_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      grp       <= '0;
      addr      <= '0;
      out_valid <= 1'b0;
    end else begin
      if ((state == S_FINISH) && slot_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid && (action == tsf_pkg::ACT_TICK)) begin
            addr  <= '0;
            grp   <= '0;
            cnt   <= '0;
            state <= pen_down ? S_READ : S_FINISH;
          end
        end
        S_READ: begin
          if (cmd.rd_en) begin
            addr <= addr + 1'b1;
          end
          if (cnt == tsf_pkg::CNT_W'(tsf_pkg::SPR)) begin
            cnt   <= '0;
            state <= S_SUM;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_SUM: begin
          if (cnt == tsf_pkg::CNT_W'(tsf_pkg::KEEP - 1)) begin
            cnt   <= '0;
            state <= S_DIV;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_DIV: state <= S_MEAN;
        S_MEAN: begin
          if (grp == 2'd3) begin
            state <= S_MAPX;
          end else begin
            grp   <= grp + 1'b1;
            state <= S_READ;
          end
        end
        S_MAPX: state <= S_MAPY;
        S_MAPY: state <= S_MAPD;
        S_MAPD: state <= S_FINISH;
        S_FINISH: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: design/touch_sample_filter.sv
// touch_sample_filter: top level of the resistive touch trimmed-mean filter.
// depends on tsf_pkg, tsf_ctrl, tsf_dp (which holds tsf_sort).
//
// Sample transactions (action 0) are written into a 20-entry sample memory in
// arrival order, X1, Y1, X2, Y2 in groups of five, and samples can stream back
// to back. A tick transaction (action 1) rewinds the write pointer and produces
// exactly one result. With the pen up the sequencer goes straight to its final
// update step. With the pen down the sequencer reads each group out of the
// memory one entry per cycle into an insertion sorter, adds up the middle three
// sorted values one per cycle and divides by three with a reciprocal multiply;
// after all four groups come the calibration mapping steps (MAPX, MAPY, MAPD)
// through one shared multiplier and one final update step, after which the
// sequencer returns to idle and the next transaction can be taken. The
// result sits in an output register: while it waits for out_ready, sample
// transactions are still taken, and only a following tick stalls at its final
// step. Config writes are accepted on every cycle (cfg_ready is tied high) and
// are meant to happen while the block is idle; indexes past the last register
// are ignored.
module touch_sample_filter (
  input  logic                              clk,
  input  logic                              rst,
  // input transactions
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              action,
  input  logic [tsf_pkg::SAMPLE_W-1:0]      sample,
  input  logic                              pen_down,
  // result transactions
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [tsf_pkg::COORD_W-1:0]       coord_x,
  output logic [tsf_pkg::COORD_W-1:0]       coord_y,
  output logic [tsf_pkg::COORD_W-1:0]       first_x,
  output logic [tsf_pkg::COORD_W-1:0]       first_y,
  output logic                              pressed,
  output logic                              new_press,
  output logic                              reading_ok,
  // register writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tsf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tsf_pkg::CFG_DATA_W-1:0]    cfg_data
);

  tsf_pkg::tsf_cmd_t cmd;

  // register port never stalls
  assign cfg_ready = 1'b1;

  // sequencer: decides which step the datapath runs each cycle
  tsf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .action    (action),
    .pen_down  (pen_down),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // datapath: memory, sorter, mean, check, mapping and press tracking
  tsf_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .action     (action),
    .sample     (sample),
    .pen_down   (pen_down),
    .cfg_fire   (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .coord_x    (coord_x),
    .coord_y    (coord_y),
    .first_x    (first_x),
    .first_y    (first_y),
    .pressed    (pressed),
    .new_press  (new_press),
    .reading_ok (reading_ok)
  );

endmodule

FILE: design/tsf_checker.sv
// tsf_checker: port-level checks on the touch sample filter results,
// bound to the top level. uses tsf_pkg for field widths.
module tsf_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [tsf_pkg::COORD_W-1:0]  coord_x,
  input logic [tsf_pkg::COORD_W-1:0]  coord_y,
  input logic [tsf_pkg::COORD_W-1:0]  first_x,
  input logic [tsf_pkg::COORD_W-1:0]  first_y,
  input logic                         pressed,
  input logic                         new_press,
  input logic                         reading_ok
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(coord_x) && $stable(coord_y)
      && $stable(pressed) && $stable(new_press))
    else $error("result changed while stalled");

  // a new press only comes with the pen held
  a_press_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && new_press |-> pressed)
    else $error("new_press without pressed");

  // a good reading needs the pen down
  a_ok_pressed: assert property (@(posedge clk) disable iff (rst)
    out_valid && reading_ok |-> pressed)
    else $error("reading_ok without pressed");

  // first-touch point is the current point on the press tick
  a_first_point: assert property (@(posedge clk) disable iff (rst)
    out_valid && new_press |-> (first_x == coord_x) && (first_y == coord_y))
    else $error("first-touch point differs on new press");

endmodule

bind touch_sample_filter tsf_checker u_tsf_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .coord_x    (coord_x),
  .coord_y    (coord_y),
  .first_x    (first_x),
  .first_y    (first_y),
  .pressed    (pressed),
  .new_press  (new_press),
  .reading_ok (reading_ok)
);
